// File: hw/rtl/array_edit_and_sort_engine_defines.svh
// Assertion macros for the array edit and sort engine.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef ARRAY_EDIT_AND_SORT_ENGINE_DEFINES_SVH
`define ARRAY_EDIT_AND_SORT_ENGINE_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define AES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen out of reset.
`define AES_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/aes_pkg.sv
// Shared types and constants for the array edit and sort engine.
// No dependencies.
package aes_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned CntW        = 7;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned ValW        = 32;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_EMIT   = 3'd3,
    OP_ROTATE = 3'd4,
    OP_SORT   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_POS  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WR_VAL = 2'd0,
    WR_RD  = 2'd1,
    WR_TMP = 2'd2
  } wr_sel_e;

  typedef struct packed {
    op_e                    op;
    logic signed [ValW-1:0] item_value;
    logic [CntW-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] out_value;
    logic [IdxW-1:0]        out_index;
    logic [CntW-1:0]        removed_count;
    logic [CntW-1:0]        fill_after;
    status_e                status;
    logic                   last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    val_ld;
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    tmp_ld;
  } dp_cmd_t;

  // Comparison flags from the datapath.
  typedef struct packed {
    logic eq;
    logic gt;
  } dp_status_t;

endpackage

// File: hw/rtl/array_edit_and_sort_engine.sv
// Top level of the array edit and sort engine.
// Depends on aes_pkg, aes_controller, aes_datapath and the defines header.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_data_o (result_t)
//
// One operation at a time; the single memory port sets the pace.
// Reset clears the fill count and control; the element memory is not cleared.
// A new transaction is taken while the last result waits; output stalls hold the sequencer.
`include "array_edit_and_sort_engine_defines.svh"

module array_edit_and_sort_engine
  import aes_pkg::*;
#(
  parameter int unsigned CAPACITY_ENTRIES = CapacityDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output result_t  out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY_ENTRIES);

  dp_cmd_t                cmd;
  dp_status_t             dp_status;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic signed [ValW-1:0] rd_data;

  aes_controller #(
    .CAPACITY_ENTRIES(CAPACITY_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .rd_data_i  (rd_data),
    .status_i   (dp_status)
  );

  aes_datapath #(
    .CAPACITY_ENTRIES(CAPACITY_ENTRIES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .in_value_i(in_data_i.item_value),
    .rd_data_o (rd_data),
    .status_o  (dp_status)
  );

  // The fill count never exceeds the capacity.
  `AES_NEVER(a_fill_cap, out_valid_o && (out_data_o.fill_after > 7'(CAPACITY_ENTRIES)), "fill above capacity")
  // An accepted transaction makes the block busy on the next cycle.
  `AES_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after accept")
  // An error result is a closing result with nothing removed.
  `AES_ASSERT(a_err_result, (out_valid_o && (out_data_o.status != ST_OK)) |-> (out_data_o.last && (out_data_o.removed_count == 7'd0)), "malformed error result")

endmodule

// File: hw/rtl/aes_datapath.sv
// Datapath: element memory, held operand and comparators.
// Depends on aes_pkg.
module aes_datapath
  import aes_pkg::*;
#(
  parameter int unsigned CAPACITY_ENTRIES = CapacityDef,
  localparam int unsigned AW = $clog2(CAPACITY_ENTRIES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic signed [ValW-1:0] in_value_i,
  output logic signed [ValW-1:0] rd_data_o,
  output dp_status_t             status_o
);

  logic signed [ValW-1:0] mem_q [CAPACITY_ENTRIES];
  logic signed [ValW-1:0] rd_data_q;
  logic signed [ValW-1:0] val_q;
  logic signed [ValW-1:0] tmp_q;
  logic signed [ValW-1:0] wr_data;
  logic                   unused_rst;

  assign unused_rst = rst_ni;

  // Write data selection.
  always_comb begin
    case (cmd_i.wr_sel)
      WR_VAL:  wr_data = val_q;
      WR_RD:   wr_data = rd_data_q;
      WR_TMP:  wr_data = tmp_q;
      default: wr_data = val_q;
    endcase
  end

  // Element memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Operand and held-element registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.val_ld) begin
      val_q <= in_value_i;
    end
    if (cmd_i.tmp_ld) begin
      tmp_q <= rd_data_q;
    end
  end

  assign rd_data_o   = rd_data_q;
  assign status_o.eq = (rd_data_q == val_q);
  assign status_o.gt = (rd_data_q > tmp_q);

endmodule

// File: hw/rtl/aes_controller.sv
// Controller: operation sequencer, counters and output register.
// Depends on aes_pkg.
module aes_controller
  import aes_pkg::*;
#(
  parameter int unsigned CAPACITY_ENTRIES = CapacityDef,
  localparam int unsigned AW = $clog2(CAPACITY_ENTRIES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output result_t                out_data_o,
  output dp_cmd_t                cmd_o,
  output logic [AW-1:0]          rd_addr_o,
  output logic [AW-1:0]          wr_addr_o,
  input  logic signed [ValW-1:0] rd_data_i,
  input  dp_status_t             status_i
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_START    = 16'h0002,
    S_INS_RD   = 16'h0004,
    S_INS_WR   = 16'h0008,
    S_REM_RD   = 16'h0010,
    S_REM_WR   = 16'h0020,
    S_EMIT_RD  = 16'h0040,
    S_EMIT_OUT = 16'h0080,
    S_ROT_LD   = 16'h0100,
    S_ROT_RD   = 16'h0200,
    S_ROT_WR   = 16'h0400,
    S_SRT_RDX  = 16'h0800,
    S_SRT_LDX  = 16'h1000,
    S_SRT_CRD  = 16'h2000,
    S_SRT_CMP  = 16'h4000,
    S_FINISH   = 16'h8000
  } state_e;

  localparam logic [CntW-1:0] Cap = CntW'(CAPACITY_ENTRIES);
  localparam logic [CntW-1:0] One = CntW'(1);
  localparam logic [CntW-1:0] Two = CntW'(2);

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  status_e         st_q, st_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] i_m1, j_m1, fill_m1, rd_idx, wr_idx;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;
  logic            out_free;
  logic            emit_last;

  assign i_m1      = i_q - One;
  assign j_m1      = j_q - One;
  assign fill_m1   = fill_q - One;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_last = ((i_q + One) == fill_q);
  assign rd_addr_o = rd_idx[AW-1:0];
  assign wr_addr_o = wr_idx[AW-1:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    st_d        = st_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    i_d         = i_q;
    j_d         = j_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_o       = '{val_ld: 1'b0, rd_en: 1'b0, wr_en: 1'b0, wr_sel: WR_VAL, tmp_ld: 1'b0};
    rd_idx      = i_q;
    wr_idx      = i_q;
    in_stall_o  = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = in_data_i.op;
          pos_d        = in_data_i.position;
          cmd_o.val_ld = 1'b1;
          state_d      = S_START;
        end
      end
      S_START: begin
        st_d    = ST_OK;
        rem_d   = '0;
        state_d = S_FINISH;
        case (op_q)
          OP_APPEND: begin
            if (fill_q == Cap) begin
              st_d = ST_FULL;
            end else begin
              cmd_o.wr_en = 1'b1;
              wr_idx      = fill_q;
              fill_d      = fill_q + One;
            end
          end
          OP_INSERT: begin
            if (fill_q == Cap) begin
              st_d = ST_FULL;
            end else if (pos_q > fill_q) begin
              st_d = ST_POS;
            end else begin
              i_d     = fill_q;
              state_d = S_INS_RD;
            end
          end
          OP_REMOVE: begin
            i_d     = '0;
            j_d     = '0;
            state_d = S_REM_RD;
          end
          OP_EMIT: begin
            i_d = '0;
            if (fill_q != '0) begin
              state_d = S_EMIT_RD;
            end
          end
          OP_ROTATE: begin
            if (fill_q >= Two) begin
              cmd_o.rd_en = 1'b1;
              rd_idx      = fill_m1;
              state_d     = S_ROT_LD;
            end
          end
          OP_SORT: begin
            if (fill_q >= Two) begin
              i_d     = One;
              state_d = S_SRT_RDX;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      // Insert: move entries up from the top, then place the value.
      S_INS_RD: begin
        if (i_q > pos_q) begin
          cmd_o.rd_en = 1'b1;
          rd_idx      = i_m1;
          state_d     = S_INS_WR;
        end else begin
          cmd_o.wr_en = 1'b1;
          wr_idx      = pos_q;
          fill_d      = fill_q + One;
          state_d     = S_FINISH;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_RD;
        i_d          = i_m1;
        state_d      = S_INS_RD;
      end
      // Remove: compact the entries that differ from the value.
      S_REM_RD: begin
        if (i_q < fill_q) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_REM_WR;
        end else begin
          fill_d  = j_q;
          state_d = S_FINISH;
        end
      end
      S_REM_WR: begin
        if (status_i.eq) begin
          rem_d = rem_q + One;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_RD;
          wr_idx       = j_q;
          j_d          = j_q + One;
        end
        i_d     = i_q + One;
        state_d = S_REM_RD;
      end
      // Emit: one result per entry.
      S_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.out_value     = rd_data_i;
          out_d.out_index     = i_q[IdxW-1:0];
          out_d.removed_count = '0;
          out_d.fill_after    = fill_q;
          out_d.status        = ST_OK;
          out_d.last          = emit_last;
          i_d                 = i_q + One;
          state_d             = emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      // Rotate: hold the top entry, move the rest up, place it at the bottom.
      S_ROT_LD: begin
        cmd_o.tmp_ld = 1'b1;
        i_d          = fill_m1;
        state_d      = S_ROT_RD;
      end
      S_ROT_RD: begin
        if (i_q != '0) begin
          cmd_o.rd_en = 1'b1;
          rd_idx      = i_m1;
          state_d     = S_ROT_WR;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_TMP;
          wr_idx       = '0;
          state_d      = S_FINISH;
        end
      end
      S_ROT_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_RD;
        i_d          = i_m1;
        state_d      = S_ROT_RD;
      end
      // Sort: insertion sort, one element fetched per pass and compared with the entries below it.
      S_SRT_RDX: begin
        if (i_q < fill_q) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SRT_LDX;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SRT_LDX: begin
        cmd_o.tmp_ld = 1'b1;
        j_d          = i_q;
        state_d      = S_SRT_CRD;
      end
      S_SRT_CRD: begin
        if (j_q != '0) begin
          cmd_o.rd_en = 1'b1;
          rd_idx      = j_m1;
          state_d     = S_SRT_CMP;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_TMP;
          wr_idx       = j_q;
          i_d          = i_q + One;
          state_d      = S_SRT_RDX;
        end
      end
      S_SRT_CMP: begin
        cmd_o.wr_en = 1'b1;
        wr_idx      = j_q;
        if (status_i.gt) begin
          cmd_o.wr_sel = WR_RD;
          j_d          = j_m1;
          state_d      = S_SRT_CRD;
        end else begin
          cmd_o.wr_sel = WR_TMP;
          i_d          = i_q + One;
          state_d      = S_SRT_RDX;
        end
      end
      // Single closing result for every operation but a non-empty emit.
      S_FINISH: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.out_value     = '0;
          out_d.out_index     = '0;
          out_d.removed_count = rem_q;
          out_d.fill_after    = fill_q;
          out_d.status        = st_q;
          out_d.last          = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    st_q  <= st_d;
    pos_q <= pos_d;
    i_q   <= i_d;
    j_q   <= j_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
